>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// assertion that is held off while reset is low
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hw/rtl/urt_pkg.sv
package urt_pkg;

  typedef enum logic [2:0] {
    PH_GUARD  = 3'd0,
    PH_SETTLE = 3'd1,
    PH_PULSE  = 3'd2,
    PH_RISE   = 3'd3,
    PH_COUNT  = 3'd4
  } phase_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_MS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_US = 3'd4;

  localparam logic [15:0] GUARD_MS_RST     = 16'd300;
  localparam logic [15:0] TICKS_PER_MS_RST = 16'd500;
  localparam logic [7:0]  SETTLE_TICKS_RST = 8'd2;
  localparam logic [7:0]  PULSE_TICKS_RST  = 8'd5;
  localparam logic [16:0] THRESHOLD_US_RST = 17'd1000;

  localparam logic [15:0] ECHO_COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic opponent_ahead;
    logic done_res;
    logic trigger_level;
  } result_t;

endpackage

>>> hw/rtl/ultrasonic_range_threshold_core.sv
// a result is registered into out_tdata, by way of the skid stage while the output is held
// throughput: one tick request per cycle; results go through an output register
// backed by a one-entry skid stage, so input stalls only when both are full
// reset (rst_n low, synchronous): registers back to defaults, phase to guard wait,
// counters cleared, output and skid stages emptied
`include "assert_macros.svh"

module ultrasonic_range_threshold_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [0] echo_level
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] trigger_level, [1] done_res, [2] opponent_ahead
  output logic [7:0]                       out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [urt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [urt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [15:0] guard_ms_r;
  logic [15:0] ticks_per_ms_r;
  logic [7:0]  settle_ticks_r;
  logic [7:0]  pulse_ticks_r;
  logic [16:0] threshold_us_r;

  urt_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [15:0] ms_count_r, ms_count_nxt;
  logic [15:0] echo_count_r, echo_count_nxt;

  urt_pkg::result_t res;
  urt_pkg::result_t out_data_r, out_data_nxt;
  urt_pkg::result_t skid_data_r, skid_data_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;

  logic echo;
  logic in_fire;
  logic out_fire;

  assign echo     = in_tdata[0];
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_valid_r && out_tready;

  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_data_r};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_ms_r     <= urt_pkg::GUARD_MS_RST;
      ticks_per_ms_r <= urt_pkg::TICKS_PER_MS_RST;
      settle_ticks_r <= urt_pkg::SETTLE_TICKS_RST;
      pulse_ticks_r  <= urt_pkg::PULSE_TICKS_RST;
      threshold_us_r <= urt_pkg::THRESHOLD_US_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        urt_pkg::CFG_GUARD_MS:     guard_ms_r     <= cfg_data[15:0];
        urt_pkg::CFG_TICKS_PER_MS: ticks_per_ms_r <= cfg_data[15:0];
        urt_pkg::CFG_SETTLE_TICKS: settle_ticks_r <= cfg_data[7:0];
        urt_pkg::CFG_PULSE_TICKS:  pulse_ticks_r  <= cfg_data[7:0];
        urt_pkg::CFG_THRESHOLD_US: threshold_us_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    logic [15:0] tick_base;
    logic [15:0] ms_base;
    logic [15:0] tick_inc;
    logic [15:0] ms_inc;
    logic [15:0] settle_inc;
    logic [15:0] pulse_inc;

    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    ms_count_nxt   = ms_count_r;
    echo_count_nxt = echo_count_r;

    tick_base  = (phase_r == urt_pkg::PH_GUARD) ? tick_count_r : 16'd0;
    ms_base    = (phase_r == urt_pkg::PH_GUARD) ? ms_count_r : 16'd0;
    tick_inc   = tick_base + 16'd1;
    ms_inc     = ms_base + 16'd1;
    settle_inc = tick_count_r + 16'd1;
    pulse_inc  = tick_count_r + 16'd1;

    case (phase_r)
      urt_pkg::PH_SETTLE: begin
        if (settle_inc >= {8'd0, settle_ticks_r}) begin
          phase_nxt      = urt_pkg::PH_PULSE;
          tick_count_nxt = 16'd0;
        end else begin
          tick_count_nxt = settle_inc;
        end
      end
      urt_pkg::PH_PULSE: begin
        if (pulse_inc >= {8'd0, pulse_ticks_r}) begin
          phase_nxt      = urt_pkg::PH_RISE;
          tick_count_nxt = 16'd0;
        end else begin
          tick_count_nxt = pulse_inc;
        end
      end
      urt_pkg::PH_RISE: begin
        if (echo) begin
          phase_nxt      = urt_pkg::PH_COUNT;
          echo_count_nxt = 16'd1;
        end
      end
      urt_pkg::PH_COUNT: begin
        if (echo) begin
          if (echo_count_r < urt_pkg::ECHO_COUNT_MAX) begin
            echo_count_nxt = echo_count_r + 16'd1;
          end
        end else begin
          phase_nxt      = urt_pkg::PH_GUARD;
          tick_count_nxt = 16'd0;
          ms_count_nxt   = 16'd0;
          echo_count_nxt = 16'd0;
        end
      end
      default: begin
        // guard wait; stray codes restart the cycle here too
        phase_nxt      = urt_pkg::PH_GUARD;
        echo_count_nxt = (phase_r == urt_pkg::PH_GUARD) ? echo_count_r : 16'd0;
        if (ms_base >= guard_ms_r) begin
          phase_nxt      = urt_pkg::PH_SETTLE;
          tick_count_nxt = 16'd0;
          ms_count_nxt   = 16'd0;
        end else if (tick_inc >= ticks_per_ms_r) begin
          tick_count_nxt = 16'd0;
          if (ms_inc >= guard_ms_r) begin
            phase_nxt    = urt_pkg::PH_SETTLE;
            ms_count_nxt = 16'd0;
          end else begin
            ms_count_nxt = ms_inc;
          end
        end else begin
          tick_count_nxt = tick_inc;
          ms_count_nxt   = ms_base;
        end
      end
    endcase
  end

  // outputs of the tick
  always_comb begin
    res = '0;
    case (phase_r)
      urt_pkg::PH_PULSE: res.trigger_level = 1'b1;
      urt_pkg::PH_COUNT: begin
        if (!echo) begin
          res.done_res       = 1'b1;
          res.opponent_ahead = ({echo_count_r, 1'b0} <= threshold_us_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= urt_pkg::PH_GUARD;
      tick_count_r <= 16'd0;
      ms_count_r   <= 16'd0;
      echo_count_r <= 16'd0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      ms_count_r   <= ms_count_nxt;
      echo_count_r <= echo_count_nxt;
    end
  end

  // output register with skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_fire;
        out_data_nxt  = res;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `ASSERT_RST(a_skid_behind_out, clk, rst_n, skid_valid_r |-> out_valid_r, "skid full while output empty")
  `ASSERT_RST(a_ahead_needs_done, clk, rst_n, (out_valid_r && out_data_r.opponent_ahead) |-> out_data_r.done_res, "opponent_ahead without done")
  `ASSERT_RST(a_count_restarts, clk, rst_n, (in_fire && phase_r == urt_pkg::PH_COUNT && !echo) |=> (phase_r == urt_pkg::PH_GUARD && echo_count_r == 16'd0), "echo fall did not restart cycle")
  `ASSERT_RST(a_echo_count_phase, clk, rst_n, (phase_r == urt_pkg::PH_COUNT) == (echo_count_r != 16'd0), "echo count out of step with phase")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [urt_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;
  typedef enum int {SET_SMALL, SET_WIDE, SET_HOLD} setting_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [urt_pkg::CFG_IDX_W-1:0]     idx;
    logic [urt_pkg::CFG_DATA_W-1:0]    data;
    logic                              echo;
    logic                              has_exp;
    urt_pkg::result_t                  exp;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata = '0;    // [0] echo_level
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // [0] trigger_level, [1] done_res, [2] opponent_ahead
  logic [7:0]                     out_tdata;
  logic                           cfg_wr_en = 1'b0;
  logic [urt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [urt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ultrasonic_range_threshold_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ranger model state and registers
  urt_pkg::phase_t ph = urt_pkg::PH_GUARD;
  logic [15:0] tick_cnt = '0;
  logic [15:0] ms_cnt = '0;
  logic [15:0] echo_cnt = '0;
  logic [15:0] guard_r = urt_pkg::GUARD_MS_RST;
  logic [15:0] tpm_r = urt_pkg::TICKS_PER_MS_RST;
  logic [7:0]  settle_r = urt_pkg::SETTLE_TICKS_RST;
  logic [7:0]  pulse_r = urt_pkg::PULSE_TICKS_RST;
  logic [16:0] thr_r = urt_pkg::THRESHOLD_US_RST;

  urt_pkg::result_t pending_results[$];
  urt_pkg::result_t want, got;

  int err_cnt = 0;
  int cycle_cnt = 0;
  int ticks_sent = 0;
  int cfg_writes = 0;
  int done_seen = 0;
  int ahead_seen = 0;
  int snd_idle_pct = 31;
  int rcv_idle_pct = 71;
  int rise_wait = 0;
  int width_left = 1;

  stim_row_t dir_tab [26] = '{
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b1, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b1, 1'b1, 3'b000},
    '{ROW_CFG,  urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b0, 3'b000},
    '{ROW_CFG,  urt_pkg::CFG_SETTLE_TICKS, 17'd0,      1'b0, 1'b0, 3'b000},
    '{ROW_CFG,  urt_pkg::CFG_PULSE_TICKS,  17'd0,      1'b0, 1'b0, 3'b000},
    '{ROW_CFG,  urt_pkg::CFG_TICKS_PER_MS, 17'd0,      1'b0, 1'b0, 3'b000},
    '{ROW_CFG,  CFG_UNUSED_IDX,            17'h1FFFF,  1'b0, 1'b0, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b1, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b1, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b1, 3'b001},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b1, 1'b1, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b1, 3'b110},
    '{ROW_CFG,  urt_pkg::CFG_GUARD_MS,     17'd2,      1'b0, 1'b0, 3'b000},
    '{ROW_CFG,  urt_pkg::CFG_THRESHOLD_US, 17'd0,      1'b0, 1'b0, 3'b000},
    '{ROW_CFG,  urt_pkg::CFG_SETTLE_TICKS, 17'd1,      1'b0, 1'b0, 3'b000},
    '{ROW_CFG,  urt_pkg::CFG_PULSE_TICKS,  17'd2,      1'b0, 1'b0, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b0, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b1, 1'b0, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b0, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b0, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b0, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b0, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b1, 1'b0, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b1, 1'b0, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b1, 1'b0, 3'b000},
    '{ROW_TICK, urt_pkg::CFG_GUARD_MS,     17'd0,      1'b0, 1'b1, 3'b010}
  };

  function automatic urt_pkg::result_t step_ranger(input logic echo);
    urt_pkg::result_t r;
    r = '0;
    case (ph)
      urt_pkg::PH_SETTLE: begin
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= {8'd0, settle_r}) begin
          ph = urt_pkg::PH_PULSE;
          tick_cnt = '0;
        end
      end
      urt_pkg::PH_PULSE: begin
        r.trigger_level = 1'b1;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= {8'd0, pulse_r}) begin
          ph = urt_pkg::PH_RISE;
          tick_cnt = '0;
        end
      end
      urt_pkg::PH_RISE: begin
        if (echo) begin
          ph = urt_pkg::PH_COUNT;
          echo_cnt = 16'd1;
        end
      end
      urt_pkg::PH_COUNT: begin
        if (echo) begin
          if (echo_cnt != urt_pkg::ECHO_COUNT_MAX) echo_cnt = echo_cnt + 16'd1;
        end else begin
          r.done_res = 1'b1;
          r.opponent_ahead = ({echo_cnt, 1'b0} <= thr_r);
          ph = urt_pkg::PH_GUARD;
          tick_cnt = '0;
          ms_cnt = '0;
          echo_cnt = '0;
        end
      end
      default: begin
        if (ms_cnt >= guard_r) begin
          ph = urt_pkg::PH_SETTLE;
          tick_cnt = '0;
          ms_cnt = '0;
        end else begin
          tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= tpm_r) begin
            tick_cnt = '0;
            ms_cnt = ms_cnt + 16'd1;
            if (ms_cnt >= guard_r) begin
              ph = urt_pkg::PH_SETTLE;
              ms_cnt = '0;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // echo that follows the trigger with a short delay and a random width, plus some noise
  function automatic logic next_echo();
    logic e;
    int w;
    case (ph)
      urt_pkg::PH_RISE: begin
        if (rise_wait > 0) begin
          rise_wait = rise_wait - 1;
          e = 1'b0;
        end else begin
          e = 1'b1;
        end
      end
      urt_pkg::PH_COUNT: begin
        if (width_left > 1) begin
          width_left = width_left - 1;
          e = 1'b1;
        end else begin
          e = 1'b0;
        end
      end
      default: begin
        e = ($urandom_range(7) == 0);
        rise_wait = $urandom_range(3);
        if (thr_r <= 17'd200 && $urandom_range(1) == 1) begin
          w = int'(thr_r) / 2 + int'($urandom_range(2)) - 1;
        end else begin
          w = $urandom_range(30, 1);
        end
        width_left = (w < 1) ? 1 : w;
      end
    endcase
    if ($urandom_range(19) == 0) e = ~e;
    return e;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    if (err_cnt < 30) begin
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got_v, want_v);
    end
    err_cnt = err_cnt + 1;
  endtask

  task automatic send_tick(input logic echo, input logic has_exp,
                           input urt_pkg::result_t exp);
    urt_pkg::result_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, echo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = step_ranger(echo);
    pending_results.push_back(has_exp ? exp : r);
    ticks_sent = ticks_sent + 1;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [urt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [urt_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      urt_pkg::CFG_GUARD_MS:     guard_r = data[15:0];
      urt_pkg::CFG_TICKS_PER_MS: tpm_r = data[15:0];
      urt_pkg::CFG_SETTLE_TICKS: settle_r = data[7:0];
      urt_pkg::CFG_PULSE_TICKS:  pulse_r = data[7:0];
      urt_pkg::CFG_THRESHOLD_US: thr_r = data[16:0];
      default: ;
    endcase
    cfg_writes = cfg_writes + 1;
  endtask

  task automatic apply_setting(input setting_t kind);
    wait_drained();
    case (kind)
      SET_WIDE: begin
        write_reg(urt_pkg::CFG_GUARD_MS, 17'd0);
        write_reg(urt_pkg::CFG_TICKS_PER_MS, 17'd65535);
        write_reg(urt_pkg::CFG_SETTLE_TICKS, 17'd255);
        write_reg(urt_pkg::CFG_PULSE_TICKS, 17'd255);
        write_reg(urt_pkg::CFG_THRESHOLD_US, 17'h1FFFF);
      end
      SET_HOLD: begin
        write_reg(urt_pkg::CFG_GUARD_MS, 17'd65535);
        write_reg(urt_pkg::CFG_TICKS_PER_MS, 17'd0);
        write_reg(urt_pkg::CFG_SETTLE_TICKS, 17'd0);
        write_reg(urt_pkg::CFG_PULSE_TICKS, 17'd1);
        write_reg(urt_pkg::CFG_THRESHOLD_US, 17'd0);
      end
      default: begin
        write_reg(urt_pkg::CFG_GUARD_MS, 17'($urandom_range(2)));
        write_reg(urt_pkg::CFG_TICKS_PER_MS, 17'($urandom_range(3)));
        write_reg(urt_pkg::CFG_SETTLE_TICKS, 17'($urandom_range(3)));
        write_reg(urt_pkg::CFG_PULSE_TICKS, 17'($urandom_range(3)));
        write_reg(urt_pkg::CFG_THRESHOLD_US, 17'($urandom_range(60)));
      end
    endcase
  endtask

  task automatic run_ticks(input int n, input logic pause_midway);
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) wait_drained();
      send_tick(next_echo(), 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[2:0];
      if (pending_results.size() == 0) begin
        report_mismatch("result with no tick request pending", int'(out_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.trigger_level !== want.trigger_level)
          report_mismatch("trigger_level", int'(got.trigger_level), int'(want.trigger_level));
        if (got.done_res !== want.done_res)
          report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
        if (got.opponent_ahead !== want.opponent_ahead)
          report_mismatch("opponent_ahead", int'(got.opponent_ahead),
                          int'(want.opponent_ahead));
        if (want.done_res) begin
          done_seen = done_seen + 1;
          if (want.opponent_ahead) ahead_seen = ahead_seen + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("FAIL ultrasonic_range_threshold_core");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_tick(dir_tab[i].echo, dir_tab[i].has_exp, dir_tab[i].exp);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      snd_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 71 : 0;
      rcv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 31 : 0;
      apply_setting(SET_SMALL);
      run_ticks(170, 1'b1);
      apply_setting(SET_WIDE);
      run_ticks(260, 1'b0);
      apply_setting(SET_SMALL);
      run_ticks(170, 1'b0);
      apply_setting(SET_HOLD);
      run_ticks(30, 1'b0);
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("sent %0d tick requests, %0d register writes, %0d measurements (%0d ahead)",
             ticks_sent, cfg_writes, done_seen, ahead_seen);
    $display("sender/receiver idle mixes 31/71, 71/31, 0/0; small, wide and held settings");
    if (err_cnt == 0) begin
      $display("PASS ultrasonic_range_threshold_core");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL ultrasonic_range_threshold_core");
    end
    $finish;
  end

endmodule
